/* design/mm_pkg.sv */
// Shared types, constants and helpers for the matrix multiply block.
`default_nettype none

package mm_pkg;

   // Store geometry and element format.
   localparam int MAX_DIM    = 8;
   localparam int DATA_WIDTH = 16;
   localparam int IDX_W      = 3;
   localparam int ADDR_W     = 2 * IDX_W;
   localparam int DEPTH      = MAX_DIM * MAX_DIM;
   localparam int DIM_W      = 4;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int VALUE_W    = 40;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_COLS = 2'd2;

   // Request codes.
   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;
   localparam logic SEL_LEFT    = 1'b0;
   localparam logic SEL_RIGHT   = 1'b1;

   // One request word.
   typedef struct packed {
      logic                         req_type;
      logic                         matrix_sel;
      logic [IDX_W-1:0]             row_index;
      logic [IDX_W-1:0]             col_index;
      logic signed [DATA_WIDTH-1:0] elem_value;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic [IDX_W-1:0]          out_row;
      logic [IDX_W-1:0]          out_col;
      logic signed [VALUE_W-1:0] out_value;
      logic                      last;
   } rsp_word_type;

   // Control that travels with each multiply-accumulate step.
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             zero;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } beat_type;

   // A dimension register above the store size is used as the store size.
   function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] value);
      logic [DIM_W-1:0] result;
      result = value;
      if (value > DIM_W'(MAX_DIM)) begin
         result = DIM_W'(MAX_DIM);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

/* design/mm_store.sv */
// Element store: one write port, one read port with registered read data.
`default_nettype none

module mm_store (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [mm_pkg::ADDR_W-1:0]            wr_addr,
   input  wire logic signed [mm_pkg::DATA_WIDTH-1:0] wr_data,
   input  wire logic [mm_pkg::ADDR_W-1:0]            rd_addr,
   output logic signed [mm_pkg::DATA_WIDTH-1:0]      rd_data
);

   logic signed [mm_pkg::DATA_WIDTH-1:0] mem_ff [mm_pkg::DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* design/mm_seq.sv */
// Sequencer that walks row, column and inner index and issues store reads.
`default_nettype none

module mm_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start_compute,
   input  wire logic [mm_pkg::DIM_W-1:0]      rows,
   input  wire logic [mm_pkg::DIM_W-1:0]      inner,
   input  wire logic [mm_pkg::DIM_W-1:0]      cols,
   output mm_pkg::beat_type                   beat,
   output logic [mm_pkg::ADDR_W-1:0]          left_addr,
   output logic [mm_pkg::ADDR_W-1:0]          right_addr,
   output logic                               running
);

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'b01,
      SEQ_RUN  = 2'b10
   } seq_state_type;

   seq_state_type                state_ff, state_in;
   logic [mm_pkg::IDX_W-1:0]     i_ff, i_in;
   logic [mm_pkg::IDX_W-1:0]     j_ff, j_in;
   logic [mm_pkg::IDX_W-1:0]     k_ff, k_in;
   logic                         i_last, j_last, k_last;

   // End of each loop level.
   assign k_last = (inner == '0) || ({1'b0, k_ff} + mm_pkg::DIM_W'(1) == inner);
   assign j_last = ({1'b0, j_ff} + mm_pkg::DIM_W'(1) == cols);
   assign i_last = ({1'b0, i_ff} + mm_pkg::DIM_W'(1) == rows);

   // Addresses are row * MAX_DIM + column.
   assign left_addr  = {i_ff, k_ff};
   assign right_addr = {k_ff, j_ff};
   assign running    = (state_ff == SEQ_RUN);

   // Step description for the datapath.
   always_comb begin
      beat        = '0;
      beat.valid  = (state_ff == SEQ_RUN);
      beat.first  = (k_ff == '0);
      beat.last_k = k_last;
      beat.zero   = (inner == '0);
      beat.last   = i_last && j_last;
      beat.row    = i_ff;
      beat.col    = j_ff;
   end

   // Loop counters and run state.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         SEQ_IDLE: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
            if (start_compute && rows != '0 && cols != '0) begin
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: begin
            if (k_last) begin
               k_in = '0;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = SEQ_IDLE;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

`default_nettype wire

/* design/mm_mac.sv */
// Multiply-accumulate pipeline and result register.
`default_nettype none

module mm_mac (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire mm_pkg::beat_type                     beat,
   input  wire logic signed [mm_pkg::DATA_WIDTH-1:0] left_data,
   input  wire logic signed [mm_pkg::DATA_WIDTH-1:0] right_data,
   output logic                                      pipe_busy,
   output logic                                      rsp_strobe,
   output mm_pkg::rsp_word_type                      rsp_word
);

   mm_pkg::beat_type                     s1_ff, s2_ff;
   logic signed [mm_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic signed [mm_pkg::VALUE_W-1:0]    acc_ff, acc_in;
   logic                                 rsp_strobe_ff;
   mm_pkg::rsp_word_type                 rsp_word_ff;

   assign pipe_busy  = s1_ff.valid || s2_ff.valid;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // Product of the two elements; an empty inner dimension contributes zero.
   always_comb begin
      prod_in = left_data * right_data;
      if (s1_ff.zero) begin
         prod_in = '0;
      end
   end

   // Running sum, restarted on the first term of each result.
   always_comb begin
      acc_in = mm_pkg::VALUE_W'(prod_ff);
      if (!s2_ff.first) begin
         acc_in = acc_ff + mm_pkg::VALUE_W'(prod_ff);
      end
   end

   // Control stages follow the store read and the multiplier.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff         <= '0;
         s2_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_ff         <= beat;
         s2_ff         <= s1_ff;
         rsp_strobe_ff <= s2_ff.valid && s2_ff.last_k;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (s2_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (s2_ff.valid && s2_ff.last_k) begin
         rsp_word_ff.out_row   <= s2_ff.row;
         rsp_word_ff.out_col   <= s2_ff.col;
         rsp_word_ff.out_value <= acc_in;
         rsp_word_ff.last      <= s2_ff.last;
      end
   end

endmodule

`default_nettype wire

/* design/matrix_multiply.sv */
// A product is computed one term per cycle; dimensions above 8 count as 8, and zero rows
// or columns start no product and produce no results.
// Synchronous reset sets all three dimension registers to 8; store contents are
// undefined until written. Results are strobed for one cycle and cannot be stalled.
`default_nettype none

module matrix_multiply (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire mm_pkg::req_word_type            req_word,
   output logic                                 rsp_strobe,
   output mm_pkg::rsp_word_type                 rsp_word,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [mm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mm_pkg::DIM_W-1:0]        csr_data
);

   logic [mm_pkg::DIM_W-1:0]              left_rows_ff, inner_dim_ff, right_cols_ff;
   logic                                  accept, wr_left, wr_right, start_compute;
   logic                                  running, pipe_busy;
   logic [mm_pkg::ADDR_W-1:0]             wr_addr, left_addr, right_addr;
   logic signed [mm_pkg::DATA_WIDTH-1:0]  left_data, right_data;
   mm_pkg::beat_type                      beat;

   // Word acceptance and decode.
   assign busy          = running || pipe_busy;
   assign accept        = start && !busy;
   assign start_compute = accept && (req_word.req_type == mm_pkg::REQ_COMPUTE);
   assign wr_left  = accept && (req_word.req_type == mm_pkg::REQ_WRITE)
                     && (req_word.matrix_sel == mm_pkg::SEL_LEFT);
   assign wr_right = accept && (req_word.req_type == mm_pkg::REQ_WRITE)
                     && (req_word.matrix_sel == mm_pkg::SEL_RIGHT);
   assign wr_addr  = {req_word.row_index, req_word.col_index};

   // Dimension registers; writes to unused indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
         inner_dim_ff  <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
         right_cols_ff <= mm_pkg::DIM_W'(mm_pkg::MAX_DIM);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mm_pkg::CSR_LEFT_ROWS:  left_rows_ff  <= csr_data;
            mm_pkg::CSR_INNER_DIM:  inner_dim_ff  <= csr_data;
            mm_pkg::CSR_RIGHT_COLS: right_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mm_store u_left_store (
      .clock   (clock),
      .wr_en   (wr_left),
      .wr_addr (wr_addr),
      .wr_data (req_word.elem_value),
      .rd_addr (left_addr),
      .rd_data (left_data)
   );

   mm_store u_right_store (
      .clock   (clock),
      .wr_en   (wr_right),
      .wr_addr (wr_addr),
      .wr_data (req_word.elem_value),
      .rd_addr (right_addr),
      .rd_data (right_data)
   );

   mm_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start_compute (start_compute),
      .rows          (mm_pkg::dim_clamp(left_rows_ff)),
      .inner         (mm_pkg::dim_clamp(inner_dim_ff)),
      .cols          (mm_pkg::dim_clamp(right_cols_ff)),
      .beat          (beat),
      .left_addr     (left_addr),
      .right_addr    (right_addr),
      .running       (running)
   );

   mm_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .left_data  (left_data),
      .right_data (right_data),
      .pipe_busy  (pipe_busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire
